FILE: src/vector_float_fixed_convert_top_defines.svh
// Assertion macros for the vector float/fixed converter.
`ifndef VECTOR_FLOAT_FIXED_CONVERT_TOP_DEFINES_SVH
`define VECTOR_FLOAT_FIXED_CONVERT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define VFC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define VFC_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define VFC_ASSERT(label, clk, rst_n, prop, msg)
`define VFC_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: src/vfc_pkg.sv
package vfc_pkg;
    localparam int MaxLanes = 4;
    localparam int DefLanes = 4;
    localparam int WordW = 32;

    typedef enum logic [2:0] {
        CMD_FTOI0  = 3'd0,
        CMD_FTOI4  = 3'd1,
        CMD_FTOI12 = 3'd2,
        CMD_FTOI15 = 3'd3,
        CMD_ITOF0  = 3'd4,
        CMD_ITOF4  = 3'd5,
        CMD_ITOF12 = 3'd6,
        CMD_ITOF15 = 3'd7
    } cmd_t;

    typedef struct packed {
        logic       to_float;
        logic [3:0] frac;
    } lane_ctl_t;

    function automatic logic [3:0] frac_of(input logic [1:0] sel);
        logic [3:0] f;
        case (sel)
            2'd0: f = 4'd0;
            2'd1: f = 4'd4;
            2'd2: f = 4'd12;
            default: f = 4'd15;
        endcase
        return f;
    endfunction
endpackage

FILE: src/vector_float_fixed_convert_top.sv
// An accepted request passes two lane stages and then the output register
// before its result appears on the m_ side.
// Throughput: one request per cycle; the pipeline stalls as a whole when the
// result is not taken. aresetn is synchronous, active low, and clears the
// valid bits only; data registers are not reset.
`include "vector_float_fixed_convert_top_defines.svh"
module vector_float_fixed_convert_top
    import vfc_pkg::*;
#(
    parameter int LANES = DefLanes
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata from bit 0: cmd[2:0], dest_mask[3:0], src_x, src_y, src_z, src_w, pad
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata from bit 0: res_x, res_y, res_z, res_w, write_mask[3:0], pad
    output logic [135:0] m_tdata
);
    // Stages move together whenever the output slot is free or drained.
    logic v1_reg, v2_reg, v3_reg;
    logic adv;
    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic [2:0] cmd;
    logic [3:0] mask;
    lane_ctl_t  ctl;
    assign cmd  = s_tdata[2:0];
    assign mask = s_tdata[6:3];
    assign ctl.to_float = cmd[2];
    assign ctl.frac = frac_of(cmd[1:0]);

    // Lane i covers x, y, z, w in turn; mask bit (3-i) enables it.
    logic [3:0] wm_live;
    logic [3:0] m1_reg, m2_reg, m3_reg;
    logic [WordW-1:0] lres [MaxLanes];
    logic [WordW-1:0] out_reg [MaxLanes];

    genvar g;
    generate
        for (g = 0; g < MaxLanes; g++) begin : g_lane
            if (g < LANES) begin : g_on
                assign wm_live[3-g] = mask[3-g];
                vfc_lane u_lane (
                    .aclk (aclk),
                    .en   (adv),
                    .ctl  (ctl),
                    .src  (s_tdata[7 + 32*g +: 32]),
                    .res  (lres[g])
                );
            end else begin : g_off
                assign wm_live[3-g] = 1'b0;
                assign lres[g] = '0;
            end
        end
    endgenerate

    // Merge stage: lanes not written report zero.
    always_ff @(posedge aclk) begin
        if (adv) begin
            m1_reg <= wm_live;
            m2_reg <= m1_reg;
            m3_reg <= m2_reg;
            for (int i = 0; i < MaxLanes; i++) begin
                out_reg[i] <= m2_reg[3-i] ? lres[i] : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata = {4'd0, m3_reg, out_reg[3], out_reg[2], out_reg[1], out_reg[0]};

    `VFC_ASSERT(a_stall_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> m_tvalid, "result lost while stalled")
    `VFC_ASSERT(a_mask_lanes, aclk, aresetn, m_tvalid |-> ((m_tdata[131:128] & ~m3_reg) == 4'd0), "mask mismatch")
    `VFC_ASSERT_NR(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "valid after reset")
endmodule

FILE: src/vfc_lane.sv
// One conversion lane, two register stages: decode/shift, then round/pack.
module vfc_lane
    import vfc_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  lane_ctl_t        ctl,
    input  logic [WordW-1:0] src,
    output logic [WordW-1:0] res
);
    // Stage 1 registers.
    logic       tf_reg;
    logic       neg_reg;
    logic       sat_reg;
    logic       zero_reg;
    logic [31:0] mag_reg;
    logic [4:0]  p_reg;
    logic [3:0]  frac_reg;
    logic [31:0] res_reg;

    logic        f_neg;
    logic [7:0]  f_ex;
    logic [23:0] f_sig;
    logic signed [9:0] f_sh;
    logic [31:0] f_mag;
    logic        f_sat;
    logic        f_zero;
    logic [31:0] i_mag;
    logic [4:0]  i_p;

    always_comb begin
        f_neg  = src[31];
        f_ex   = src[30:23];
        f_sig  = {1'b1, src[22:0]};
        f_sh   = $signed({2'b00, f_ex}) - 10'sd150 + $signed({6'd0, ctl.frac});
        f_sat  = (f_ex == 8'hFF) || (f_ex != 8'h00 && f_sh >= 10'sd8);
        f_zero = (f_ex == 8'h00);
        f_mag  = 32'd0;
        if (f_sh >= 10'sd0) begin
            f_mag = {8'd0, f_sig} << f_sh[2:0];
        end else if (f_sh > -10'sd24) begin
            f_mag = {8'd0, f_sig} >> 5'(-f_sh);
        end
        i_mag = src[31] ? (32'd0 - src) : src;
        i_p = 5'd0;
        for (int k = 0; k < 32; k++) begin
            if (i_mag[k]) i_p = 5'(k);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tf_reg   <= ctl.to_float;
            frac_reg <= ctl.frac;
            neg_reg  <= f_neg;
            sat_reg  <= f_sat;
            zero_reg <= ctl.to_float ? (src == 32'd0) : f_zero;
            mag_reg  <= ctl.to_float ? i_mag : f_mag;
            p_reg    <= i_p;
        end
    end

    // Stage 2: finish.
    logic [31:0] res_next;
    logic [31:0] norm;
    logic [5:0]  r;
    logic [31:0] keep;
    logic [31:0] rem;
    logic [31:0] half;
    logic [7:0]  pe;
    logic [24:0] kr;

    always_comb begin
        norm = 32'd0;
        r = 6'd0;
        keep = 32'd0;
        rem = 32'd0;
        half = 32'd0;
        kr = 25'd0;
        pe = {3'd0, p_reg};
        if (p_reg <= 5'd23) begin
            norm = mag_reg << (5'd23 - p_reg);
            kr = norm[24:0];
        end else begin
            r = {1'b0, p_reg} - 6'd23;
            keep = mag_reg >> r;
            rem = mag_reg & ((32'd1 << r) - 32'd1);
            half = 32'd1 << (r - 6'd1);
            kr = keep[24:0];
            if (rem > half || (rem == half && keep[0])) kr = kr + 25'd1;
            if (kr[24]) begin
                kr = kr >> 1;
                pe = pe + 8'd1;
            end
        end
        if (tf_reg) begin
            if (zero_reg) res_next = 32'd0;
            else res_next = {neg_reg, pe + 8'd127 - {4'd0, frac_reg}, kr[22:0]};
        end else begin
            if (sat_reg) res_next = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else if (zero_reg) res_next = 32'd0;
            else res_next = neg_reg ? (32'd0 - mag_reg) : mag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) res_reg <= res_next;
    end

    assign res = res_reg;
endmodule
